// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, sampled on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define LR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define LR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    ((ante) |=> (cons))) else $error(msg);

`endif

// ----- design/lr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line rasteriser package
// Widths, controller states and the command and status bundles shared by the
// controller and the datapath.
// ----------------------------------------------------------------------------
package lr_pkg;

  // Field widths of the request and pixel items.
  localparam int unsigned COORD_W  = 6;
  localparam int unsigned COLOR_W  = 24;
  // Error accumulator is two's complement, within -63 .. 63; step sums stay below 190.
  localparam int unsigned ERR_W    = 9;
  // Twice the minor delta.
  localparam int unsigned DELTA2_W = COORD_W + 1;

  typedef enum logic {
    LR_IDLE,
    LR_DRAW
  } lr_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture a new request and set up the walk
    logic step;   // emit the current pixel and advance
  } lr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;   // current pixel is the final one of the line
  } lr_sts_t;

endpackage

// ----- design/lr_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line rasteriser channels
// Valid/ready channels for line requests and for emitted pixels.
// ----------------------------------------------------------------------------

// Line request channel: two endpoints and a colour.
interface lr_req_if;
  logic                         valid;
  logic                         ready;
  logic [lr_pkg::COORD_W-1:0]   start_x;
  logic [lr_pkg::COORD_W-1:0]   start_y;
  logic [lr_pkg::COORD_W-1:0]   end_x;
  logic [lr_pkg::COORD_W-1:0]   end_y;
  logic [lr_pkg::COLOR_W-1:0]   line_color;

  modport source (output valid, start_x, start_y, end_x, end_y, line_color,
                  input  ready);
  modport sink   (input  valid, start_x, start_y, end_x, end_y, line_color,
                  output ready);
endinterface

// Pixel channel: one item per pixel of the line.
interface lr_pix_if;
  logic                         valid;
  logic                         ready;
  logic [lr_pkg::COORD_W-1:0]   pixel_x;
  logic [lr_pkg::COORD_W-1:0]   pixel_y;
  logic [lr_pkg::COLOR_W-1:0]   pixel_color;
  logic                         last_pixel;

  modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel,
                  input  ready);
  modport sink   (input  valid, pixel_x, pixel_y, pixel_color, last_pixel,
                  output ready);
endinterface

// ----- design/lr_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line rasteriser datapath
// Sets up the Bresenham walk from a request and advances it one pixel per
// step command, holding the emitted pixel in the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lr_datapath #(
  parameter int unsigned IMAGE_SIZE = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lr_pkg::lr_cmd_t              cmd_i,
  output lr_pkg::lr_sts_t              sts_o,
  input  logic [lr_pkg::COORD_W-1:0]   start_x_i,
  input  logic [lr_pkg::COORD_W-1:0]   start_y_i,
  input  logic [lr_pkg::COORD_W-1:0]   end_x_i,
  input  logic [lr_pkg::COORD_W-1:0]   end_y_i,
  input  logic [lr_pkg::COLOR_W-1:0]   line_color_i,
  output logic [lr_pkg::COORD_W-1:0]   pixel_x_o,
  output logic [lr_pkg::COORD_W-1:0]   pixel_y_o,
  output logic [lr_pkg::COLOR_W-1:0]   pixel_color_o,
  output logic                         last_pixel_o
);
  import lr_pkg::*;

  localparam logic [COORD_W-1:0] CoordMax = COORD_W'(IMAGE_SIZE - 1);

  // Walk state.
  logic [COORD_W-1:0]       major_pos_q, major_pos_d;
  logic [COORD_W-1:0]       major_stop_q, major_stop_d;
  logic [COORD_W-1:0]       minor_pos_q, minor_pos_d;
  logic signed [ERR_W-1:0]  error_acc_q, error_acc_d;
  logic [COORD_W-1:0]       major_delta_q, major_delta_d;
  logic [DELTA2_W-1:0]      twice_minor_delta_q, twice_minor_delta_d;
  logic                     axes_swapped_q, axes_swapped_d;
  logic                     minor_descends_q, minor_descends_d;
  logic [COLOR_W-1:0]       held_color_q, held_color_d;

  // Output register.
  logic [COORD_W-1:0]       pixel_x_q, pixel_y_q;
  logic [COLOR_W-1:0]       pixel_color_q;
  logic                     last_pixel_q;

  // Set-up values derived from the request.
  logic [COORD_W-1:0]       ax, ay, bx, by, dx, dy;
  logic                     swap_axes;
  logic [COORD_W-1:0]       a_major, a_minor, b_major, b_minor;
  logic [COORD_W-1:0]       lo_major, lo_minor, hi_major, hi_minor;

  // Step values.
  logic signed [ERR_W-1:0]  err_sum;
  logic signed [ERR_W-1:0]  major_delta_s;
  logic signed [ERR_W-1:0]  twice_major_delta_s;
  logic                     step_minor;
  logic                     is_last;
  logic [COORD_W-1:0]       cur_x, cur_y;

  // Saturate the endpoints to the image and choose the major axis.
  always_comb begin
    ax = (start_x_i > CoordMax) ? CoordMax : start_x_i;
    ay = (start_y_i > CoordMax) ? CoordMax : start_y_i;
    bx = (end_x_i   > CoordMax) ? CoordMax : end_x_i;
    by = (end_y_i   > CoordMax) ? CoordMax : end_y_i;
    dx = (ax > bx) ? (ax - bx) : (bx - ax);
    dy = (ay > by) ? (ay - by) : (by - ay);
    swap_axes = (dx < dy);
    if (swap_axes) begin
      a_major = ay;
      a_minor = ax;
      b_major = by;
      b_minor = bx;
    end else begin
      a_major = ax;
      a_minor = ay;
      b_major = bx;
      b_minor = by;
    end
    // Order the endpoints so that the major axis is walked upward.
    if (a_major > b_major) begin
      lo_major = b_major;
      lo_minor = b_minor;
      hi_major = a_major;
      hi_minor = a_minor;
    end else begin
      lo_major = a_major;
      lo_minor = a_minor;
      hi_major = b_major;
      hi_minor = b_minor;
    end
  end

  // Error update and pixel position for the current step.
  always_comb begin
    major_delta_s       = $signed({{(ERR_W-COORD_W){1'b0}}, major_delta_q});
    twice_major_delta_s = $signed({{(ERR_W-COORD_W-1){1'b0}}, major_delta_q, 1'b0});
    err_sum    = error_acc_q + $signed({{(ERR_W-DELTA2_W){1'b0}}, twice_minor_delta_q});
    step_minor = (err_sum > major_delta_s);
    is_last    = (major_pos_q == major_stop_q);
    cur_x      = axes_swapped_q ? minor_pos_q : major_pos_q;
    cur_y      = axes_swapped_q ? major_pos_q : minor_pos_q;
  end

  // Next-state selection for the walk registers.
  always_comb begin
    major_pos_d         = major_pos_q;
    major_stop_d        = major_stop_q;
    minor_pos_d         = minor_pos_q;
    error_acc_d         = error_acc_q;
    major_delta_d       = major_delta_q;
    twice_minor_delta_d = twice_minor_delta_q;
    axes_swapped_d      = axes_swapped_q;
    minor_descends_d    = minor_descends_q;
    held_color_d        = held_color_q;
    if (cmd_i.load) begin
      major_pos_d         = lo_major;
      major_stop_d        = hi_major;
      minor_pos_d         = lo_minor;
      error_acc_d         = '0;
      major_delta_d       = swap_axes ? dy : dx;
      twice_minor_delta_d = swap_axes ? {dx, 1'b0} : {dy, 1'b0};
      axes_swapped_d      = swap_axes;
      minor_descends_d    = !(hi_minor > lo_minor);
      held_color_d        = line_color_i;
    end else if (cmd_i.step) begin
      if (step_minor) begin
        minor_pos_d = minor_descends_q ? (minor_pos_q - 1'b1) : (minor_pos_q + 1'b1);
        error_acc_d = err_sum - twice_major_delta_s;
      end else begin
        error_acc_d = err_sum;
      end
      if (!is_last) begin
        major_pos_d = major_pos_q + 1'b1;
      end
    end
  end

  // Walk registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      major_pos_q         <= '0;
      major_stop_q        <= '0;
      minor_pos_q         <= '0;
      error_acc_q         <= '0;
      major_delta_q       <= '0;
      twice_minor_delta_q <= '0;
      axes_swapped_q      <= 1'b0;
      minor_descends_q    <= 1'b0;
      held_color_q        <= '0;
    end else begin
      major_pos_q         <= major_pos_d;
      major_stop_q        <= major_stop_d;
      minor_pos_q         <= minor_pos_d;
      error_acc_q         <= error_acc_d;
      major_delta_q       <= major_delta_d;
      twice_minor_delta_q <= twice_minor_delta_d;
      axes_swapped_q      <= axes_swapped_d;
      minor_descends_q    <= minor_descends_d;
      held_color_q        <= held_color_d;
    end
  end

  // Output register: captures the current pixel on each step.
  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      pixel_x_q     <= cur_x;
      pixel_y_q     <= cur_y;
      pixel_color_q <= held_color_q;
      last_pixel_q  <= is_last;
    end
  end

  assign sts_o.last    = is_last;
  assign pixel_x_o     = pixel_x_q;
  assign pixel_y_o     = pixel_y_q;
  assign pixel_color_o = pixel_color_q;
  assign last_pixel_o  = last_pixel_q;

  // The error term stays within one major delta either side of zero.
  `LR_ASSERT(a_err_upper, error_acc_q <= major_delta_s, "error term above major delta")
  `LR_ASSERT(a_err_lower, error_acc_q >= -major_delta_s, "error term below minus major delta")

endmodule

// ----- design/lr_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line rasteriser controller
// Accepts a request when idle, then issues one step per pixel whenever the
// output register is free or being emptied.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lr_controller (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output lr_pkg::lr_cmd_t  cmd_o,
  input  lr_pkg::lr_sts_t  sts_i
);
  import lr_pkg::*;

  lr_state_e state_q, state_d;
  logic      out_valid_q, out_valid_d;
  logic      out_free;

  // The output register can take a pixel when empty or drained this cycle.
  assign out_free = !out_valid_q || out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      LR_IDLE: begin
        if (in_valid_i) begin
          state_d = LR_DRAW;
        end
      end
      LR_DRAW: begin
        if (out_free && sts_i.last) begin
          state_d = LR_IDLE;
        end
      end
      default: begin
        state_d = LR_IDLE;
      end
    endcase
  end

  // Outputs and commands.
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      LR_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      LR_DRAW: begin
        cmd_o.step = out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // Output valid flag follows the output register.
  always_comb begin
    if (cmd_o.step) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= LR_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // A step must never overwrite a pixel that has not been taken.
  `LR_ASSERT(a_step_free, cmd_o.step |-> (!out_valid_q || out_ready_i), "step over held pixel")
  // Stepping the final pixel returns the controller to idle.
  `LR_ASSERT_NEXT(a_last_idle, cmd_o.step && sts_i.last, state_q == LR_IDLE, "no idle after last")
  // A loaded request always starts drawing.
  `LR_ASSERT_NEXT(a_load_draw, cmd_o.load, state_q == LR_DRAW, "load did not start drawing")

endmodule

// ----- design/line_rasterizer_top.sv -----
`timescale 1ns / 1ps
// A request loads the walk registers; its first pixel then goes to the output register.
// Throughput: one pixel per cycle while the output register is free or being emptied;
// a line with major delta M gives M+1 pixels, up to 64, stepped in the draw state.
// The next request is taken while the final pixel still waits in the output register.
// Reset is asynchronous and active low; it clears the controller and walk state at once.
// ----------------------------------------------------------------------------
// Line rasteriser
// Integer Bresenham line drawing: one request in, one item out per pixel.
// ----------------------------------------------------------------------------

module line_rasterizer_top #(
  parameter int unsigned IMAGE_SIZE = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lr_req_if.sink      req_i,
  lr_pix_if.source    pix_o
);
  import lr_pkg::*;

  lr_cmd_t cmd;
  lr_sts_t sts;
  logic    in_ready;
  logic    out_valid;

  lr_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (pix_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  lr_datapath #(
    .IMAGE_SIZE (IMAGE_SIZE)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .start_x_i     (req_i.start_x),
    .start_y_i     (req_i.start_y),
    .end_x_i       (req_i.end_x),
    .end_y_i       (req_i.end_y),
    .line_color_i  (req_i.line_color),
    .pixel_x_o     (pix_o.pixel_x),
    .pixel_y_o     (pix_o.pixel_y),
    .pixel_color_o (pix_o.pixel_color),
    .last_pixel_o  (pix_o.last_pixel)
  );

  assign req_i.ready = in_ready;
  assign pix_o.valid = out_valid;

endmodule

// ----- dv/line_rasterizer_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line rasteriser testbench
// Sends line requests over the request channel and checks every pixel item
// against a Bresenham walk kept in the testbench. Directed lines cover single
// points, full-length axis and diagonal lines, and shallow and steep lines
// with the minor axis rising and falling; random lines follow, with gaps on
// both channels and a long pixel hold-off that backs up to the request input.
// ----------------------------------------------------------------------------

module line_rasterizer_top_test;

  localparam int unsigned IMAGE_SIZE  = 64;
  localparam int unsigned COORD_MASK  = (1 << lr_pkg::COORD_W) - 1;
  localparam int unsigned COORD_MAX   = IMAGE_SIZE - 1;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned DRAIN_CYCLES = 16;

  typedef struct packed {
    logic [lr_pkg::COORD_W-1:0] x0;
    logic [lr_pkg::COORD_W-1:0] y0;
    logic [lr_pkg::COORD_W-1:0] x1;
    logic [lr_pkg::COORD_W-1:0] y1;
    logic [lr_pkg::COLOR_W-1:0] color;
  } line_req_t;

  typedef struct packed {
    logic [lr_pkg::COORD_W-1:0] pix_x;
    logic [lr_pkg::COORD_W-1:0] pix_y;
    logic [lr_pkg::COLOR_W-1:0] color;
    logic                       last;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  lr_req_if req_if ();
  lr_pix_if pix_if ();

  line_rasterizer_top #(
    .IMAGE_SIZE(IMAGE_SIZE)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .pix_o (pix_if)
  );

  // Pixels still owed by the block, oldest first.
  pixel_t pixels_due[$];
  int     mismatch_count = 0;
  int     cycle_count = 0;
  bit     req_gaps_on = 1'b0;
  bit     pix_stalls_on = 1'b0;
  int     pix_hold_cycles = 0;

  // Clock: 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Idle stretch length: mostly none or short, now and then long.
  function automatic int idle_cycles();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned clamp_coord(int unsigned v);
    return (v > COORD_MAX) ? COORD_MAX : v;
  endfunction

  // Walks the line as the block should and queues every pixel it owes.
  function automatic void rasterize_line(line_req_t req);
    int unsigned ax, ay, bx, by, dx, dy;
    int unsigned a_maj, a_min, b_maj, b_min, swap_tmp;
    int unsigned maj_pos, maj_stop, min_pos, maj_delta, twice_min;
    int          err;
    int          count;
    bit          swapped, descends, last;
    pixel_t      px;
    ax = clamp_coord(req.x0);
    ay = clamp_coord(req.y0);
    bx = clamp_coord(req.x1);
    by = clamp_coord(req.y1);
    dx = (ax > bx) ? ax - bx : bx - ax;
    dy = (ay > by) ? ay - by : by - ay;

    // Equal deltas keep x as the major axis.
    swapped = dx < dy;
    if (swapped) begin
      a_maj = ay; a_min = ax; b_maj = by; b_min = bx;
      maj_delta = dy;
      twice_min = 2 * dx;
    end else begin
      a_maj = ax; a_min = ay; b_maj = bx; b_min = by;
      maj_delta = dx;
      twice_min = 2 * dy;
    end

    // The major axis is always walked upwards.
    if (a_maj > b_maj) begin
      swap_tmp = a_maj; a_maj = b_maj; b_maj = swap_tmp;
      swap_tmp = a_min; a_min = b_min; b_min = swap_tmp;
    end
    maj_pos  = a_maj;
    maj_stop = b_maj;
    min_pos  = a_min;
    descends = !(b_min > a_min);
    err      = 0;
    count    = 0;

    do begin
      last     = (maj_pos == maj_stop);
      px.pix_x = swapped ? min_pos[lr_pkg::COORD_W-1:0] : maj_pos[lr_pkg::COORD_W-1:0];
      px.pix_y = swapped ? maj_pos[lr_pkg::COORD_W-1:0] : min_pos[lr_pkg::COORD_W-1:0];
      px.color = req.color;
      px.last  = last;
      pixels_due.push_back(px);
      count++;
      err += int'(twice_min);
      if (err > int'(maj_delta)) begin
        min_pos = (descends ? min_pos - 1 : min_pos + 1) & COORD_MASK;
        err -= 2 * int'(maj_delta);
      end
      if (!last && count < IMAGE_SIZE) maj_pos = (maj_pos + 1) & COORD_MASK;
    end while (!last && count < IMAGE_SIZE);
  endfunction

  // Offers one request, waits for it to be taken, then idles if gaps are on.
  task automatic draw_line(line_req_t req);
    int gap;
    req_if.valid      <= 1'b1;
    req_if.start_x    <= req.x0;
    req_if.start_y    <= req.y0;
    req_if.end_x      <= req.x1;
    req_if.end_y      <= req.y1;
    req_if.line_color <= req.color;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    rasterize_line(req);
    gap = req_gaps_on ? idle_cycles() : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic line_req_t make_line(int unsigned x0, int unsigned y0,
                                          int unsigned x1, int unsigned y1,
                                          int unsigned color);
    line_req_t req;
    req.x0    = x0[lr_pkg::COORD_W-1:0];
    req.y0    = y0[lr_pkg::COORD_W-1:0];
    req.x1    = x1[lr_pkg::COORD_W-1:0];
    req.y1    = y1[lr_pkg::COORD_W-1:0];
    req.color = color[lr_pkg::COLOR_W-1:0];
    return req;
  endfunction

  function automatic int unsigned near_coord(int unsigned c);
    int t;
    t = int'(c) + int'($urandom_range(0, 8)) - 4;
    if (t < 0) t = 0;
    if (t > int'(COORD_MAX)) t = COORD_MAX;
    return t;
  endfunction

  // Random line: mostly anywhere, many short ones, some aligned or a point.
  function automatic line_req_t random_line();
    int unsigned x0, y0, x1, y1, len;
    int          shape;
    x0    = $urandom_range(0, COORD_MAX);
    y0    = $urandom_range(0, COORD_MAX);
    shape = $urandom_range(0, 7);
    case (shape)
      0, 1, 2, 3: begin
        x1 = $urandom_range(0, COORD_MAX);
        y1 = $urandom_range(0, COORD_MAX);
      end
      4, 5: begin
        x1 = near_coord(x0);
        y1 = near_coord(y0);
      end
      6: begin
        // Horizontal, vertical or diagonal through the first endpoint.
        len = $urandom_range(0, COORD_MAX);
        case ($urandom_range(0, 2))
          0: begin x1 = len; y1 = y0; end
          1: begin x1 = x0; y1 = len; end
          default: begin
            len = (x0 < y0) ? x0 : y0;
            x1  = x0 - $urandom_range(0, len);
            y1  = y0 - (x0 - x1);
          end
        endcase
      end
      default: begin
        x1 = x0;
        y1 = y0;
      end
    endcase
    return make_line(x0, y0, x1, y1, $urandom());
  endfunction

  // Pixel receiver: random stalls, plus a long hold-off when one is asked for.
  initial begin : pixel_sink
    int stall_left;
    stall_left   = 0;
    pix_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (pix_hold_cycles > 0) begin
        pix_if.ready <= 1'b0;
        pix_hold_cycles--;
      end else if (stall_left > 0) begin
        pix_if.ready <= 1'b0;
        stall_left--;
      end else if (pix_stalls_on && $urandom_range(0, 3) == 0) begin
        pix_if.ready <= 1'b0;
        stall_left = idle_cycles();
      end else begin
        pix_if.ready <= 1'b1;
      end
    end
  end

  // Each pixel item taken is compared with the oldest pixel owed.
  always @(posedge clk_i) begin : pixel_check
    pixel_t due;
    if (rst_ni && pix_if.valid && pix_if.ready) begin
      if (pixels_due.size() == 0) begin
        $error("unexpected pixel item: x %0d, y %0d, colour %06h, last %0b",
               pix_if.pixel_x, pix_if.pixel_y, pix_if.pixel_color, pix_if.last_pixel);
        mismatch_count++;
      end else begin
        due = pixels_due.pop_front();
        if (pix_if.pixel_x !== due.pix_x) begin
          $error("pixel_x: expected %0d, actual %0d", due.pix_x, pix_if.pixel_x);
          mismatch_count++;
        end
        if (pix_if.pixel_y !== due.pix_y) begin
          $error("pixel_y: expected %0d, actual %0d", due.pix_y, pix_if.pixel_y);
          mismatch_count++;
        end
        if (pix_if.pixel_color !== due.color) begin
          $error("pixel_color: expected %06h, actual %06h", due.color, pix_if.pixel_color);
          mismatch_count++;
        end
        if (pix_if.last_pixel !== due.last) begin
          $error("last_pixel: expected %0b, actual %0b", due.last, pix_if.last_pixel);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: ends a run that has hung.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  // Equal endpoints at the corners and in the middle give one pixel each.
  task automatic test_single_points();
    draw_line(make_line(0, 0, 0, 0, 24'h000000));
    draw_line(make_line(63, 63, 63, 63, 24'hFFFFFF));
    draw_line(make_line(63, 0, 63, 0, 24'h555555));
    draw_line(make_line(17, 42, 17, 42, 24'hAAAAAA));
  endtask

  // Full-length horizontal, vertical and diagonal lines in both directions.
  task automatic test_axis_lines();
    draw_line(make_line(0, 0, 63, 0, 24'hFF0000));
    draw_line(make_line(63, 63, 0, 63, 24'h00FF00));
    draw_line(make_line(0, 0, 0, 63, 24'h0000FF));
    draw_line(make_line(63, 63, 63, 0, 24'hFFFFFF));
    draw_line(make_line(0, 0, 63, 63, 24'h000000));
    draw_line(make_line(63, 0, 0, 63, 24'hAAAAAA));
    draw_line(make_line(0, 63, 63, 0, 24'h555555));
  endtask

  // Shallow and steep lines with the minor axis rising and falling.
  task automatic test_octants();
    draw_line(make_line(10, 5, 50, 20, 24'h123456));
    draw_line(make_line(50, 20, 10, 5, 24'h654321));
    draw_line(make_line(10, 40, 50, 25, 24'hABCDEF));
    draw_line(make_line(5, 10, 20, 50, 24'hFEDCBA));
    draw_line(make_line(20, 10, 5, 50, 24'h0F0F0F));
    draw_line(make_line(30, 30, 31, 32, 24'hF0F0F0));
    draw_line(make_line(0, 62, 63, 63, 24'h808080));
    draw_line(make_line(62, 0, 63, 63, 24'h7F7F7F));
  endtask

  // The receiver holds off for a long stretch while full lines keep coming.
  task automatic test_pixel_backpressure();
    pix_hold_cycles = 300;
    draw_line(make_line(0, 0, 63, 21, $urandom()));
    draw_line(make_line(63, 5, 0, 60, $urandom()));
    draw_line(make_line(7, 0, 40, 63, $urandom()));
    draw_line(make_line(63, 63, 0, 0, $urandom()));
    draw_line(random_line());
    draw_line(random_line());
  endtask

  // Random lines: gaps on both sides, then a stretch at full rate, then gaps.
  task automatic test_random_lines();
    req_gaps_on   = 1'b1;
    pix_stalls_on = 1'b1;
    repeat (80) draw_line(random_line());
    req_gaps_on   = 1'b0;
    pix_stalls_on = 1'b0;
    repeat (40) draw_line(random_line());
    req_gaps_on   = 1'b1;
    pix_stalls_on = 1'b1;
    repeat (80) draw_line(random_line());
  endtask

  initial begin
    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.start_x    = '0;
    req_if.start_y    = '0;
    req_if.end_x      = '0;
    req_if.end_y      = '0;
    req_if.line_color = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_points();
    test_axis_lines();
    test_octants();
    test_pixel_backpressure();
    test_random_lines();
    req_if.valid <= 1'b0;

    // Let every owed pixel arrive, then give stray items time to show.
    while (pixels_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/lr_pkg.sv
design/lr_ifs.sv
design/lr_datapath.sv
design/lr_controller.sv
design/line_rasterizer_top.sv
dv/line_rasterizer_top_test.sv
